>>> sv/cau_pkg.sv
// Shared types, defaults and command codes for the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int CMD_W          = 3;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_ADD = 3'd0;
    localparam cmd_t CMD_SUB = 3'd1;
    localparam cmd_t CMD_MUL = 3'd2;
    localparam cmd_t CMD_DIV = 3'd3;
    localparam cmd_t CMD_MAG = 3'd4;

endpackage

>>> sv/cau_div_pipe.sv
// Pipelined restoring divider: floor((num << FB) / den), one quotient bit per stage.
// Depends on nothing; advances on en.
`timescale 1ns / 1ps

module cau_div_pipe #(
    parameter int DW = 16,
    parameter int FB = 8
) (
    input  logic              clk,
    input  logic              en,
    input  logic [2*DW-1:0]   num,
    input  logic [2*DW-1:0]   den,
    output logic [DW:0]       quo,
    output logic              big
);

    localparam int NW = 2*DW + FB;
    localparam int QW = DW + 1;
    localparam int RW = 2*DW;

    logic [RW-1:0] rem_reg [0:QW];
    logic [RW-1:0] den_reg [0:QW];
    logic [QW-1:0] low_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic          big_reg [0:QW];

    logic [NW-1:0] dividend;
    logic [NW-1:0] hi;

    // quotient of QW bits only; anything at or above 2^QW is flagged as big
    assign dividend = NW'(num) << FB;
    assign hi       = dividend >> QW;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi[RW-1:0];
            den_reg[0] <= den;
            low_reg[0] <= dividend[QW-1:0];
            q_reg[0]   <= '0;
            big_reg[0] <= (hi >= NW'(den));
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_stage
            logic [RW:0] trial;
            logic        ge;

            assign trial = {rem_reg[k-1], low_reg[k-1][QW-1]};
            assign ge    = (trial >= {1'b0, den_reg[k-1]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? RW'(trial - {1'b0, den_reg[k-1]}) : trial[RW-1:0];
                    den_reg[k] <= den_reg[k-1];
                    low_reg[k] <= {low_reg[k-1][QW-2:0], 1'b0};
                    q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                    big_reg[k] <= big_reg[k-1];
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW];
    assign big = big_reg[QW];

endmodule

>>> sv/cau_isqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, two trailing delay stages.
// Depends on nothing; advances on en.
`timescale 1ns / 1ps

module cau_isqrt_pipe #(
    parameter int DW = 16
) (
    input  logic              clk,
    input  logic              en,
    input  logic [2*DW-1:0]   rad,
    output logic [DW-1:0]     root
);

    localparam int LAT = DW + 2;

    logic [DW+1:0]   rem_reg  [0:LAT-1];
    logic [DW-1:0]   root_reg [0:LAT-1];
    logic [2*DW-1:0] s_reg    [0:LAT-1];

    genvar k;
    generate
        for (k = 0; k < LAT; k++)
        begin : g_stage
            logic [DW+1:0]   rem_src;
            logic [DW-1:0]   root_src;
            logic [2*DW-1:0] s_src;

            if (k == 0)
            begin : g_first
                assign rem_src  = '0;
                assign root_src = '0;
                assign s_src    = rad;
            end
            else
            begin : g_next
                assign rem_src  = rem_reg[k-1];
                assign root_src = root_reg[k-1];
                assign s_src    = s_reg[k-1];
            end

            if (k < DW)
            begin : g_iter
                logic [DW+1:0] cur;
                logic [DW+1:0] trial;
                logic          ge;

                assign cur   = {rem_src[DW-1:0], s_src[2*DW-1 -: 2]};
                assign trial = {root_src, 2'b01};
                assign ge    = (cur >= trial);

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k]  <= ge ? (cur - trial) : cur;
                        root_reg[k] <= {root_src[DW-2:0], ge};
                        s_reg[k]    <= s_src << 2;
                    end
                end
            end
            else
            begin : g_delay
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k]  <= rem_src;
                        root_reg[k] <= root_src;
                        s_reg[k]    <= s_src;
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[LAT-1];

endmodule

>>> sv/complex_arithmetic_unit_core.sv
// Complex arithmetic unit: add, subtract, multiply, divide and |b| on signed Qm.n operands.
// One request enters per cycle while out_stall does not hold the pipeline; the quotient and
// root pipelines, 18 stages each at the default width, set the depth. A stall on
// a valid output freezes the whole pipeline and is mirrored on in_stall. Divide by zero returns
// a unchanged with div_zero set; any other out-of-range result saturates and raises overflow.
// Depends on cau_pkg, cau_div_pipe, cau_isqrt_pipe.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  cmd_t                         cmd,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] r_re,
    output logic signed [DATA_WIDTH-1:0] r_im,
    output logic                         div_zero,
    output logic                         overflow
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2*W;
    localparam int D  = W + 2;
    localparam int NV = D + 5;

    localparam logic signed [PW:0]  SMAX  = {{(W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW:0]  SMIN  = ~SMAX;
    localparam logic [W-1:0]        WMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]        WMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]          QLIMP = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0]          QLIMN = {2'b01, {(W-1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] val;
        logic                ovf;
    } sat_t;

    typedef struct packed {
        cmd_t                cmd;
        logic signed [W-1:0] res_re;
        logic signed [W-1:0] res_im;
        logic                ovf;
        logic                dz;
        logic                neg_re;
        logic                neg_im;
    } side_t;

    function automatic sat_t sat_w(input logic signed [PW:0] v);
        sat_t s;
        s.ovf = 1'b1;
        if (v > SMAX)
            s.val = WMAX;
        else if (v < SMIN)
            s.val = WMIN;
        else
        begin
            s.val = v[W-1:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

    logic          en;
    logic [NV-1:0] vld_reg;

    assign en        = !(vld_reg[NV-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NV-2:0], in_valid};
    end

    // stage 0: capture
    cmd_t                cmd0_reg;
    logic signed [W-1:0] ar0_reg, ai0_reg, br0_reg, bi0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd0_reg <= cmd;
            ar0_reg  <= a_re;
            ai0_reg  <= a_im;
            br0_reg  <= b_re;
            bi0_reg  <= b_im;
        end
    end

    // stage 1: products, add or subtract
    logic signed [PW-1:0] arx, aix, brx, bix;
    logic signed [PW-1:0] rr1_reg, ii1_reg, ir1_reg, ri1_reg, bbr1_reg, bbi1_reg;
    logic signed [W:0]    as_re1_reg, as_im1_reg;
    cmd_t                 cmd1_reg;
    logic signed [W-1:0]  ar1_reg, ai1_reg;

    assign arx = ar0_reg;
    assign aix = ai0_reg;
    assign brx = br0_reg;
    assign bix = bi0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rr1_reg  <= arx * brx;
            ii1_reg  <= aix * bix;
            ir1_reg  <= aix * brx;
            ri1_reg  <= arx * bix;
            bbr1_reg <= brx * brx;
            bbi1_reg <= bix * bix;
            if (cmd0_reg == CMD_SUB)
            begin
                as_re1_reg <= (W+1)'(arx) - (W+1)'(brx);
                as_im1_reg <= (W+1)'(aix) - (W+1)'(bix);
            end
            else
            begin
                as_re1_reg <= (W+1)'(arx) + (W+1)'(brx);
                as_im1_reg <= (W+1)'(aix) + (W+1)'(bix);
            end
            cmd1_reg <= cmd0_reg;
            ar1_reg  <= ar0_reg;
            ai1_reg  <= ai0_reg;
        end
    end

    // stage 2: sums of products
    logic signed [PW:0]  mul_re2_reg, mul_im2_reg, num_re2_reg, num_im2_reg;
    logic [PW-1:0]       den2_reg;
    logic signed [W:0]   as_re2_reg, as_im2_reg;
    cmd_t                cmd2_reg;
    logic signed [W-1:0] ar2_reg, ai2_reg;
    logic signed [PW:0]  rrx, iix, irx, rix;

    assign rrx = rr1_reg;
    assign iix = ii1_reg;
    assign irx = ir1_reg;
    assign rix = ri1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_re2_reg <= rrx - iix;
            mul_im2_reg <= irx + rix;
            num_re2_reg <= rrx + iix;
            num_im2_reg <= irx - rix;
            den2_reg    <= bbr1_reg + bbi1_reg;
            as_re2_reg  <= as_re1_reg;
            as_im2_reg  <= as_im1_reg;
            cmd2_reg    <= cmd1_reg;
            ar2_reg     <= ar1_reg;
            ai2_reg     <= ai1_reg;
        end
    end

    // stage 3: finish the short commands, take magnitudes for the divider
    sat_t               s_re3, s_im3;
    side_t              side3;
    logic signed [PW:0] as_re_x, as_im_x;
    logic signed [PW:0] nre_neg, nim_neg;
    logic [PW-1:0]      n_re3_reg, n_im3_reg, den3_reg;
    side_t              side_reg [0:D];

    assign as_re_x = as_re2_reg;
    assign as_im_x = as_im2_reg;
    assign nre_neg = -num_re2_reg;
    assign nim_neg = -num_im2_reg;

    always_comb
    begin
        s_re3        = '0;
        s_im3        = '0;
        side3        = '0;
        side3.cmd    = cmd2_reg;
        side3.neg_re = num_re2_reg[PW];
        side3.neg_im = num_im2_reg[PW];
        case (cmd2_reg)
            CMD_ADD, CMD_SUB:
            begin
                s_re3 = sat_w(as_re_x);
                s_im3 = sat_w(as_im_x);
            end
            CMD_MUL:
            begin
                s_re3 = sat_w(mul_re2_reg >>> FRAC_BITS);
                s_im3 = sat_w(mul_im2_reg >>> FRAC_BITS);
            end
            CMD_DIV:
            begin
                if (den2_reg == '0)
                begin
                    s_re3.val = ar2_reg;
                    s_im3.val = ai2_reg;
                    side3.dz  = 1'b1;
                end
            end
            default:
            begin
                s_re3 = '0;
                s_im3 = '0;
            end
        endcase
        side3.res_re = s_re3.val;
        side3.res_im = s_im3.val;
        side3.ovf    = s_re3.ovf | s_im3.ovf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_re3_reg   <= num_re2_reg[PW] ? nre_neg[PW-1:0] : num_re2_reg[PW-1:0];
            n_im3_reg   <= num_im2_reg[PW] ? nim_neg[PW-1:0] : num_im2_reg[PW-1:0];
            den3_reg    <= den2_reg;
            side_reg[0] <= side3;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= D; k++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[k] <= side_reg[k-1];
            end
        end
    endgenerate

    // long units
    logic [W:0]   q_re, q_im;
    logic         big_re, big_im;
    logic [W-1:0] root;

    cau_div_pipe #(.DW(W), .FB(FRAC_BITS)) u_div_re (
        .clk (clk),
        .en  (en),
        .num (n_re3_reg),
        .den (den3_reg),
        .quo (q_re),
        .big (big_re)
    );

    cau_div_pipe #(.DW(W), .FB(FRAC_BITS)) u_div_im (
        .clk (clk),
        .en  (en),
        .num (n_im3_reg),
        .den (den3_reg),
        .quo (q_im),
        .big (big_im)
    );

    cau_isqrt_pipe #(.DW(W)) u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (den3_reg),
        .root (root)
    );

    // final: sign and saturate the quotients, select
    side_t        side_f;
    sat_t         d_re, d_im;
    logic [W:0]   q_re_n, q_im_n;
    logic [W-1:0] re_next, im_next;
    logic         dz_next, ovf_next;

    logic [W-1:0] r_re_reg, r_im_reg;
    logic         dz_reg, ovf_reg;

    assign side_f = side_reg[D];
    assign q_re_n = -q_re;
    assign q_im_n = -q_im;

    always_comb
    begin
        if (side_f.neg_re)
        begin
            d_re.ovf = big_re || (q_re > QLIMN);
            d_re.val = d_re.ovf ? WMIN : q_re_n[W-1:0];
        end
        else
        begin
            d_re.ovf = big_re || (q_re > QLIMP);
            d_re.val = d_re.ovf ? WMAX : q_re[W-1:0];
        end
        if (side_f.neg_im)
        begin
            d_im.ovf = big_im || (q_im > QLIMN);
            d_im.val = d_im.ovf ? WMIN : q_im_n[W-1:0];
        end
        else
        begin
            d_im.ovf = big_im || (q_im > QLIMP);
            d_im.val = d_im.ovf ? WMAX : q_im[W-1:0];
        end

        re_next  = side_f.res_re;
        im_next  = side_f.res_im;
        dz_next  = side_f.dz;
        ovf_next = side_f.ovf;
        case (side_f.cmd)
            CMD_DIV:
            begin
                if (!side_f.dz)
                begin
                    re_next  = d_re.val;
                    im_next  = d_im.val;
                    ovf_next = d_re.ovf | d_im.ovf;
                end
            end
            CMD_MAG:
            begin
                re_next  = root[W-1] ? WMAX : root;
                im_next  = '0;
                ovf_next = root[W-1];
            end
            default:
            begin
                re_next = side_f.res_re;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_re_reg <= re_next;
            r_im_reg <= im_next;
            dz_reg   <= dz_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign r_re     = r_re_reg;
    assign r_im     = r_im_reg;
    assign div_zero = dz_reg;
    assign overflow = ovf_reg;

    a_dz_no_ovf : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> !overflow)
        else $error("div_zero and overflow both set");

    a_stall_src : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while frozen");

endmodule

>>> verif/complex_arithmetic_unit_core_tb.sv
// Self-checking testbench for complex_arithmetic_unit_core: directed and random requests,
// each result checked against a behavioural predictor. Depends on cau_pkg and the core.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_tb
    import cau_pkg::*;
();

    localparam int DW = 16;
    localparam int FB = 8;
    localparam longint SMAX = 32767;
    localparam longint SMIN = -32768;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic          dz;
        logic          ovf;
    } cplx_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    cmd_t cmd = CMD_ADD;
    logic signed [DW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DW-1:0] r_re, r_im;
    logic div_zero, overflow;

    cplx_res_t result_q[$];
    int errors = 0;
    int burst_left = 0;
    int stall_mode = 0;

    always #5 clk = ~clk;

    complex_arithmetic_unit_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .out_valid(out_valid),
        .out_stall(out_stall), .r_re(r_re), .r_im(r_im), .div_zero(div_zero),
        .overflow(overflow)
    );

    function automatic longint clamp(longint v, inout logic ovf);
        if (v > SMAX)
        begin
            ovf = 1'b1;
            return SMAX;
        end
        if (v < SMIN)
        begin
            ovf = 1'b1;
            return SMIN;
        end
        return v;
    endfunction

    // num * 2^FB / den, truncated toward zero
    function automatic longint fx_quot(longint num, longint den);
        longint n;
        longint q;
        n = (num < 0) ? -num : num;
        q = (n << FB) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r;
        r = 0;
        for (int b = 20; b >= 0; b--)
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= x)
                r = r + (64'sd1 << b);
        return r;
    endfunction

    function automatic cplx_res_t predict_cplx(cmd_t c, longint ar, longint ai,
                                               longint br, longint bi);
        cplx_res_t p;
        logic ovf;
        longint re, im, den;
        ovf = 1'b0;
        re = 0;
        im = 0;
        p.dz = 1'b0;
        case (c)
            CMD_ADD:
            begin
                re = clamp(ar + br, ovf);
                im = clamp(ai + bi, ovf);
            end
            CMD_SUB:
            begin
                re = clamp(ar - br, ovf);
                im = clamp(ai - bi, ovf);
            end
            CMD_MUL:
            begin
                re = clamp((ar * br - ai * bi) >>> FB, ovf);
                im = clamp((ai * br + ar * bi) >>> FB, ovf);
            end
            CMD_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    re = ar;
                    im = ai;
                    p.dz = 1'b1;
                end
                else
                begin
                    re = clamp(fx_quot(ar * br + ai * bi, den), ovf);
                    im = clamp(fx_quot(ai * br - ar * bi, den), ovf);
                end
            end
            CMD_MAG:
                re = clamp(int_sqrt(br * br + bi * bi), ovf);
            default: ;
        endcase
        p.re = re[DW-1:0];
        p.im = im[DW-1:0];
        p.ovf = ovf;
        return p;
    endfunction

    // Drive one request, held until accepted; bursts with random gaps between them.
    task automatic send_request(cmd_t c, logic [DW-1:0] ar, logic [DW-1:0] ai,
                                logic [DW-1:0] br, logic [DW-1:0] bi);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        cmd <= c;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        in_valid <= 1'b1;
        result_q.push_back(predict_cplx(c, $signed(ar), $signed(ai), $signed(br), $signed(bi)));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    function automatic logic [DW-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [DW-1:0] ext[4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        for (int c = 0; c < 8; c++)
            send_request(cmd_t'(c), ext[c % 4], ext[(c + 1) % 4], ext[(c + 2) % 4],
                         ext[(c + 3) % 4]);
        // zero divisor, exact and overflowing divides, magnitude saturation, mul, sub
        send_request(CMD_DIV, 16'h1234, 16'h8765, 16'h0000, 16'h0000);
        send_request(CMD_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0000);
        send_request(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        send_request(CMD_MAG, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
        send_request(CMD_MAG, 16'h0000, 16'h0000, 16'h0300, 16'h0400);
        send_request(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_request(CMD_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff);
        send_request(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    endtask

    task automatic test_random();
        cmd_t c;
        for (int i = 0; i < 1030; i++)
        begin
            c = ($urandom_range(0, 19) == 0) ? cmd_t'($urandom_range(5, 7))
                                             : cmd_t'($urandom_range(0, 4));
            send_request(c, rand_operand(), rand_operand(), rand_operand(), rand_operand());
        end
    endtask

    // receiver stall pattern: phases of none, light, heavy
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        cplx_res_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{r_re, r_im, div_zero, overflow};
            if (result_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                want = result_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch expected re=%h im=%h dz=%b ovf=%b actual re=%h im=%h dz=%b ovf=%b",
                             $time, want.re, want.im, want.dz, want.ovf,
                             got.re, got.im, got.dz, got.ovf);
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (errors == 0 && result_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
